FILE: rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the lzw compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CODE_W      = 12;
    localparam int unsigned OWIDTH_W    = 4;
    localparam int unsigned FIRST_CODE  = 256;
    localparam int unsigned START_WIDTH = 8;
    localparam int unsigned EPOCH_W     = 8;

    // one input item as it leaves the front queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_item;

    // one result item
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [OWIDTH_W-1:0] width;
        logic                final_code;
    } t_result;

    // handshake between front queue and engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

endpackage

FILE: rtl/lzwc_if.sv
// ----------------------------------------------------------------------------
// lzwc_in_if / lzwc_out_if
// Valid/ready channels for input bytes and output codes.
// ----------------------------------------------------------------------------
interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzwc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_code;
    logic [3:0]  out_width;
    logic        out_final;

    modport source (output valid, output out_code, output out_width, output out_final,
                    input ready);
    modport sink   (input valid, input out_code, input out_width, input out_final,
                    output ready);
endinterface

FILE: rtl/lzwc_front.sv
// ----------------------------------------------------------------------------
// lzwc_front
// Two-entry input queue that takes items and hands them to the engine.
// ----------------------------------------------------------------------------
module lzwc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lzwc_in_if.sink             i_item,
    input  logic                i_pop,
    output lzwc_pkg::t_front_out o_front
);
    import lzwc_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    // accept while a slot is free
    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;

    assign o_front.valid = (r_cnt != 2'd0);
    assign o_front.item  = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{data: i_item.in_byte, last: i_item.in_last};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/lzwc_engine.sv
// ----------------------------------------------------------------------------
// lzwc_engine
// Dictionary search in a hashed table, prefix update and code output queue.
// ----------------------------------------------------------------------------
module lzwc_engine #(
    parameter int unsigned DICT_ENTRIES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzwc_pkg::t_front_out i_front,
    output logic                 o_pop,
    lzwc_out_if.source           o_item
);
    import lzwc_pkg::*;

    localparam int unsigned AW = $clog2(DICT_ENTRIES);
    localparam int unsigned WW = $clog2(AW + 1);
    localparam int unsigned CW = AW + 1;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [AW-1:0]      prefix;
        logic [BYTE_W-1:0]  data;
        logic [AW-1:0]      code;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_CMP   = 4'b1000
    } t_state;

    t_entry              r_mem [DICT_ENTRIES];
    t_entry              r_rdata;
    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_count, n_count;
    logic [WW-1:0]       r_width, n_width;
    logic [AW-1:0]       r_prefix, n_prefix;
    logic                r_pvalid, n_pvalid;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_last, n_last;

    t_result             r_ofifo [4];
    logic [1:0]          r_owp, r_orp;
    logic [2:0]          r_ocnt;
    logic                push_a, push_b, out_pop;
    t_result             res_a, res_b;

    logic                we;
    t_entry              wdata;
    logic                hit, occupied;
    logic [CW-1:0]       pow;
    logic [WW-1:0]       grown_w;

    // widen then cut so any table size maps onto the 12-bit code field
    function automatic logic [CODE_W-1:0] to_code(input logic [AW-1:0] v);
        logic [AW+CODE_W-1:0] t;
        t = {{CODE_W{1'b0}}, v};
        return t[CODE_W-1:0];
    endfunction

    function automatic logic [OWIDTH_W-1:0] to_width(input logic [WW-1:0] v);
        logic [WW+OWIDTH_W-1:0] t;
        t = {{OWIDTH_W{1'b0}}, v};
        return t[OWIDTH_W-1:0];
    endfunction

    assign occupied = (r_rdata.epoch == r_epoch);
    assign hit      = occupied && (r_rdata.prefix == r_prefix) && (r_rdata.data == r_byte);
    assign pow      = CW'(1) << r_width;
    assign grown_w  = (r_count >= pow && pow < CW'(DICT_ENTRIES)) ? r_width + WW'(1) : r_width;

    // control and next state
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_count  = r_count;
        n_width  = r_width;
        n_prefix = r_prefix;
        n_pvalid = r_pvalid;
        n_epoch  = r_epoch;
        n_byte   = r_byte;
        n_last   = r_last;
        o_pop    = 1'b0;
        push_a   = 1'b0;
        push_b   = 1'b0;
        res_a    = '{code: to_code(r_prefix), width: to_width(r_width), final_code: 1'b0};
        res_b    = '{code: '0, width: '0, final_code: 1'b1};
        we       = 1'b0;
        wdata    = '{epoch: r_epoch, prefix: r_prefix, data: r_byte,
                     code: r_count[AW-1:0]};
        case (r_state)
            ST_CLEAR: begin
                // invalidate one table slot a cycle
                we          = 1'b1;
                wdata.epoch = '0;
                n_addr      = r_addr + AW'(1);
                if (r_addr == AW'(DICT_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_front.valid && r_ocnt <= 3'd2) begin
                    o_pop  = 1'b1;
                    n_byte = i_front.item.data;
                    n_last = i_front.item.last;
                    if (!r_pvalid) begin
                        n_prefix = AW'(i_front.item.data);
                        n_pvalid = 1'b1;
                        if (i_front.item.last) begin
                            push_a = 1'b1;
                            res_a  = '{code: CODE_W'(i_front.item.data),
                                       width: to_width(r_width), final_code: 1'b1};
                        end
                    end else begin
                        n_addr  = r_prefix ^ (AW'(i_front.item.data) << (AW - BYTE_W));
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_IDLE;
                if (hit) begin
                    n_prefix = r_rdata.code;
                    if (r_last) begin
                        push_a = 1'b1;
                        res_a  = '{code: to_code(r_rdata.code), width: to_width(r_width),
                                   final_code: 1'b1};
                    end
                end else if (occupied) begin
                    // linear probe
                    n_addr  = r_addr + AW'(1);
                    n_state = ST_LOOK;
                end else begin
                    push_a   = 1'b1;
                    n_prefix = AW'(r_byte);
                    if (r_count < CW'(DICT_ENTRIES)) begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                        n_width = grown_w;
                    end
                    if (r_last) begin
                        push_b = 1'b1;
                        res_b  = '{code: CODE_W'(r_byte), width: to_width(n_width),
                                   final_code: 1'b1};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // end of message: back to start, new epoch, sweep on wrap
        if ((push_a && res_a.final_code) || push_b) begin
            n_count  = CW'(FIRST_CODE);
            n_width  = WW'(START_WIDTH);
            n_prefix = '0;
            n_pvalid = 1'b0;
            if (r_epoch == {EPOCH_W{1'b1}}) begin
                n_epoch = EPOCH_W'(1);
                n_addr  = '0;
                n_state = ST_CLEAR;
            end else begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end
        end
    end

    // dictionary table
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // engine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_count  <= CW'(FIRST_CODE);
            r_width  <= WW'(START_WIDTH);
            r_prefix <= '0;
            r_pvalid <= 1'b0;
            r_epoch  <= EPOCH_W'(1);
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_count  <= n_count;
            r_width  <= n_width;
            r_prefix <= n_prefix;
            r_pvalid <= n_pvalid;
            r_epoch  <= n_epoch;
        end
    end

    // current item payload
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    // output queue
    assign out_pop          = o_item.valid && o_item.ready;
    assign o_item.valid     = (r_ocnt != 3'd0);
    assign o_item.out_code  = r_ofifo[r_orp].code;
    assign o_item.out_width = r_ofifo[r_orp].width;
    assign o_item.out_final = r_ofifo[r_orp].final_code;

    always_ff @(posedge i_clk) begin
        if (push_a) r_ofifo[r_owp] <= res_a;
        if (push_b) r_ofifo[r_owp + 2'd1] <= res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            r_owp  <= r_owp + 2'(push_a) + 2'(push_b);
            r_orp  <= r_orp + 2'(out_pop);
            r_ocnt <= r_ocnt + 3'(push_a) + 3'(push_b) - 3'(out_pop);
        end
    end

endmodule

FILE: rtl/lzw_compressor_unit.sv
// ----------------------------------------------------------------------------
// lzw_compressor_unit
// LZW byte compressor with variable code width, one code per output item.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one byte per item with in_last on the final byte of a
//   message. o_item carries codes with their width (8 up to log2 of
//   DICT_ENTRIES) and out_final on the last code of a message.
//   A byte passes through the idle, look and compare states when its first
//   table probe settles it, and through look and compare again for every
//   extra probe of the hashed dictionary; the table has a single read port.
//   The first byte of a message is taken in the idle state alone.
//   A two-entry input queue takes bytes while the engine works, and a
//   four-entry output queue holds codes while the receiver stalls; the
//   engine starts a byte only with room for two codes.
//   After reset, and after every 255 messages, all DICT_ENTRIES slots of the
//   table are swept; bytes queue up meanwhile and wait.
//   Reset puts the dictionary back to the 256 single-byte codes.
// ----------------------------------------------------------------------------
module lzw_compressor_unit #(
    parameter int unsigned DICT_ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzwc_in_if.sink     i_item,
    lzwc_out_if.source  o_item
);
    import lzwc_pkg::*;

    t_front_out front;
    logic       pop;

    lzwc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_front (front)
    );

    lzwc_engine #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .o_pop   (pop),
        .o_item  (o_item)
    );

endmodule

FILE: dv/lzw_compressor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_compressor_unit_tb
// Self-checking bench for the lzw compressor: byte messages go in on one
// channel, a behavioral dictionary predicts every code, width and final flag,
// and each output item is checked in order against that prediction.
// ----------------------------------------------------------------------------
module lzw_compressor_unit_tb;
    import lzwc_pkg::*;

    localparam int unsigned DICT_SIZE  = 4096;
    localparam int          IDLE_PCT   = 30;
    localparam int          HANG_LIMIT = 40000;
    localparam int          STALL_LEN  = 400;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } t_byte_req;

    logic i_clk;
    logic i_rst_n;

    lzwc_in_if  in_ch();
    lzwc_out_if out_ch();

    lzw_compressor_unit #(.DICT_ENTRIES(DICT_SIZE)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch.sink),
        .o_item  (out_ch.source)
    );

    t_byte_req   pending_bytes[$];
    t_result     expected_codes[$];
    int          bytes_sent;
    int          codes_seen;
    int          fail_count;
    int          hang_count;
    int          stall_left;
    bit          stall_done;

    // dictionary copy: key is {prefix, byte}, value is the pair's code
    int unsigned pair_codes[int unsigned];
    int unsigned dict_fill;
    logic [3:0]  cur_width;
    logic [11:0] cur_prefix;
    bit          have_prefix;

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void restart_dictionary();
        pair_codes.delete();
        dict_fill   = FIRST_CODE;
        cur_width   = 4'(START_WIDTH);
        cur_prefix  = '0;
        have_prefix = 1'b0;
    endfunction

    function automatic void push_code(logic [11:0] code, logic [3:0] w, logic fin);
        t_result r;
        r.code       = code;
        r.width      = w;
        r.final_code = fin;
        expected_codes.push_back(r);
    endfunction

    // lzw step on one accepted byte
    function automatic void compress_byte(logic [7:0] b, logic last);
        int unsigned key;
        key = 32'({cur_prefix, b});
        if (!have_prefix) begin
            cur_prefix  = 12'(b);
            have_prefix = 1'b1;
        end else if (pair_codes.exists(key)) begin
            cur_prefix = 12'(pair_codes[key]);
        end else begin
            push_code(cur_prefix, cur_width, 1'b0);
            if (dict_fill < DICT_SIZE) begin
                if (dict_fill >= (1 << cur_width) && (1 << cur_width) < DICT_SIZE)
                    cur_width = 4'(cur_width + 4'd1);
                pair_codes[key] = dict_fill;
                dict_fill++;
            end
            cur_prefix = 12'(b);
        end
        if (last) begin
            push_code(cur_prefix, cur_width, 1'b1);
            restart_dictionary();
        end
    endfunction

    function automatic void add_message(int len, int alpha, bit drain_first);
        t_byte_req r;
        for (int i = 0; i < len; i++) begin
            r.data  = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1));
            r.last  = (i == len - 1);
            r.drain = drain_first && (i == 0);
            pending_bytes.push_back(r);
        end
    endfunction

    function automatic void add_fixed(logic [7:0] b, logic last, bit drain);
        t_byte_req r;
        r.data  = b;
        r.last  = last;
        r.drain = drain;
        pending_bytes.push_back(r);
    endfunction

    // sender: feeds bytes from the pending queue, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= '0;
            in_ch.in_last <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                compress_byte(in_ch.in_byte, in_ch.in_last);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_bytes.size() > 0 && pending_bytes[0].drain
                        && expected_codes.size() != 0) begin
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() > 0 &&
                        ((bytes_sent > 700 && bytes_sent < 900) ||
                         $urandom_range(99) >= IDLE_PCT)) begin
                    in_ch.in_byte <= pending_bytes[0].data;
                    in_ch.in_last <= pending_bytes[0].last;
                    in_ch.valid   <= 1'b1;
                    void'(pending_bytes.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off, checks each code
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    $error("unexpected code %0d width %0d", out_ch.out_code,
                           out_ch.out_width);
                    fail_count++;
                end else begin
                    if (out_ch.out_code !== expected_codes[0].code) begin
                        $error("out_code: expected %0d, got %0d",
                               expected_codes[0].code, out_ch.out_code);
                        fail_count++;
                    end
                    if (out_ch.out_width !== expected_codes[0].width) begin
                        $error("out_width: expected %0d, got %0d",
                               expected_codes[0].width, out_ch.out_width);
                        fail_count++;
                    end
                    if (out_ch.out_final !== expected_codes[0].final_code) begin
                        $error("out_final: expected %0d, got %0d",
                               expected_codes[0].final_code, out_ch.out_final);
                        fail_count++;
                    end
                    void'(expected_codes.pop_front());
                end
            end
            if (!stall_done && codes_seen >= 150) begin
                stall_done   <= 1'b1;
                stall_left   <= STALL_LEN;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (bytes_sent > 700 && bytes_sent < 900) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count > HANG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int total;
        int pick;
        bytes_sent  = 0;
        codes_seen  = 0;
        fail_count  = 0;
        hang_count  = 0;
        stall_done  = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        restart_dictionary();

        // single-byte messages at the byte extremes
        add_fixed(8'h00, 1'b1, 1'b0);
        add_fixed(8'hFF, 1'b1, 1'b0);
        // two bytes, the low extreme then the high one
        add_fixed(8'h00, 1'b0, 1'b0);
        add_fixed(8'hFF, 1'b1, 1'b0);
        // run of one byte: repeated dictionary hits
        for (int i = 0; i < 14; i++)
            add_fixed(8'hFF, i == 13, 1'b0);
        // alternating bytes
        for (int i = 0; i < 6; i++)
            add_fixed((i % 2) ? 8'h00 : 8'hAA, i == 5, 1'b0);
        // long random message: width growth past 9 bits
        add_message(600, 256, 1'b1);

        total = 624;
        while (total < 1200) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                add_message($urandom_range(1, 4), 256, pick < 3);
                total += 3;
            end else if (pick < 88) begin
                add_message($urandom_range(8, 60), $urandom_range(2, 4), 1'b0);
                total += 34;
            end else begin
                add_message($urandom_range(100, 300), 256, 1'b0);
                total += 200;
            end
        end

        wait (i_rst_n === 1'b1);
        while (pending_bytes.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: lzw_compressor_unit.f
rtl/lzwc_pkg.sv
rtl/lzwc_if.sv
rtl/lzwc_front.sv
rtl/lzwc_engine.sv
rtl/lzw_compressor_unit.sv
dv/lzw_compressor_unit_tb.sv
